>>> sv/bra_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the bitmap run allocator.
package bra_pkg;

	// Default depth of the allocation map in bytes.
	localparam int unsigned MAP_BYTES_DEF = 512;

	// Field widths fixed by the interface.
	localparam int unsigned IDX_W  = 32;
	localparam int unsigned RUN_W  = 13;
	localparam int unsigned SIZE_W = 10;
	localparam int unsigned CFG_W  = 32;
	localparam int unsigned CIDX_W = 1;

	// Reset value of the size register.
	localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd512;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] CFG_BASE_INDEX = 1'b0;
	localparam logic [CIDX_W-1:0] CFG_SIZE_BYTES = 1'b1;

	// Operation codes.
	typedef enum logic [1:0] {
		OP_TEST  = 2'd0,
		OP_WRITE = 2'd1,
		OP_ALLOC = 2'd2
	} op_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOCATE,
		ST_RMW,
		ST_SCAN,
		ST_MARK,
		ST_RESP
	} state_t;

	// One result word.
	typedef struct packed {
		logic             bit_state;
		logic [IDX_W-1:0] run_start;
		logic             run_found;
	} result_t;

	// Control of the run tracker.
	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctl_t;

endpackage

>>> sv/bra_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the bitmap run allocator.
interface bra_in_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  opcode;
	logic [bra_pkg::IDX_W-1:0]   bit_index;
	logic                        write_value;
	logic [bra_pkg::RUN_W-1:0]   run_length;

	modport source (output valid, output opcode, output bit_index, output write_value,
		output run_length, input ready);
	modport sink (input valid, input opcode, input bit_index, input write_value,
		input run_length, output ready);
endinterface

interface bra_out_if;
	logic                        valid;
	logic                        ready;
	logic                        bit_state;
	logic [bra_pkg::IDX_W-1:0]   run_start;
	logic                        run_found;

	modport source (output valid, output bit_state, output run_start, output run_found,
		input ready);
	modport sink (input valid, input bit_state, input run_start, input run_found,
		output ready);
endinterface

>>> sv/bitmap_run_allocator.sv
`timescale 1ns / 1ps
// A test or write passes from the locate state through read-modify-write to the response;
// locate goes straight to the response when the index is out of range, the length is zero
// or the opcode is unused. An allocate reads one map byte a cycle: a failed search answers
// after the last byte in use is checked; a found run is marked byte by byte, then answered.
// One item at a time: requests are accepted again in the cycle after the result is loaded.
// After reset a clearing pass zeroes all MAP_BYTES bytes, one per cycle, before any request.
module bitmap_run_allocator #(
	parameter int unsigned MAP_BYTES = bra_pkg::MAP_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bra_pkg::CIDX_W-1:0]  cfg_idx,
	input  logic [bra_pkg::CFG_W-1:0]   cfg_wdata,
	bra_in_if.sink                      req,
	bra_out_if.source                   rsp
);

	localparam int unsigned CW = $clog2(MAP_BYTES + 1);

	logic [bra_pkg::IDX_W-1:0]  base_q;
	logic [bra_pkg::SIZE_W-1:0] size_q;
	logic [CW-1:0]              n_bytes;
	logic                       out_free;
	logic                       res_push;
	bra_pkg::result_t           res;
	logic                       out_valid_q;
	bra_pkg::result_t           out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= bra_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				bra_pkg::CFG_BASE_INDEX: base_q <= cfg_wdata;
				bra_pkg::CFG_SIZE_BYTES: size_q <= cfg_wdata[bra_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Bytes in use, saturated at the memory depth.
	assign n_bytes = (32'(size_q) > 32'(MAP_BYTES)) ? CW'(MAP_BYTES) : CW'(size_q);

	bra_ctrl #(
		.MAP_BYTES (MAP_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.base     (base_q),
		.n_bytes  (n_bytes),
		.out_free (out_free),
		.res_push (res_push),
		.res      (res)
	);

	// Output register: holds a finished word until the sink takes it.
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) out_q <= res;
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.bit_state = out_q.bit_state;
	assign rsp.run_start = out_q.run_start;
	assign rsp.run_found = out_q.run_found;

endmodule

>>> sv/bra_scan.sv
`timescale 1ns / 1ps
// Run tracker: counts consecutive free bits across map bytes, one byte per step.
module bra_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bra_pkg::scan_ctl_t         ctl,
	input  logic [7:0]                 map_byte,
	input  logic [bra_pkg::RUN_W-1:0]  want,
	output logic                       hit,
	output logic [2:0]                 hit_bit
);

	logic [bra_pkg::RUN_W-1:0] run_q;
	logic [bra_pkg::RUN_W-1:0] run_next;

	// Walk the eight bits of the byte, lowest first, stopping at the first full run.
	always_comb begin
		logic [bra_pkg::RUN_W-1:0] r;
		logic                      h;
		logic [2:0]                hb;
		r  = run_q;
		h  = 1'b0;
		hb = 3'd0;
		for (int b = 0; b < 8; b++) begin
			if (!h) begin
				r = map_byte[b] ? '0 : r + bra_pkg::RUN_W'(1);
				if (r == want) begin
					h  = 1'b1;
					hb = 3'(b);
				end
			end
		end
		run_next = r;
		hit      = h;
		hit_bit  = hb;
	end

	// Run length carried from one byte to the next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (ctl.clear) begin
			run_q <= '0;
		end else if (ctl.step) begin
			run_q <= run_next;
		end
	end

endmodule

>>> sv/bra_ctrl.sv
`timescale 1ns / 1ps
// Map memory and sequencer for test, write, first-fit search and run marking.
module bra_ctrl #(
	parameter int unsigned MAP_BYTES = bra_pkg::MAP_BYTES_DEF,
	localparam int unsigned AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1,
	localparam int unsigned CW = $clog2(MAP_BYTES + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	bra_in_if.sink                     req,
	input  logic [bra_pkg::IDX_W-1:0]  base,
	input  logic [CW-1:0]              n_bytes,
	input  logic                       out_free,
	output logic                       res_push,
	output bra_pkg::result_t           res
);

	localparam int unsigned PW = AW + 3;

	bra_pkg::state_t state_q, state_d;

	// Map memory.
	logic [7:0]    mem [MAP_BYTES];
	logic          mem_re, mem_we;
	logic [AW-1:0] mem_ra, mem_wa;
	logic [7:0]    mem_wd;
	logic [7:0]    mem_rdata_q;

	// Request capture.
	logic [1:0]                 op_q;
	logic [bra_pkg::IDX_W-1:0]  idx_q;
	logic                       wval_q;
	logic [bra_pkg::RUN_W-1:0]  want_q;

	// Control counters and pipeline flags.
	logic [AW-1:0] clr_q;
	logic [CW-1:0] rd_q;
	logic          dv_s1;
	logic [AW-1:0] da_s1;
	logic [AW-1:0] mk_q;
	logic          mk_go_q;
	logic          mv_s1;
	logic [AW-1:0] ma_s1;

	// Datapath registers.
	logic [PW-1:0]     pos_q;
	logic [PW-1:0]     first_q;
	logic [PW-1:0]     end_q;
	bra_pkg::result_t  res_q;

	// Locate and scan helpers.
	logic [bra_pkg::IDX_W-1:0] rel;
	logic                      in_rng;
	logic                      scan_hit;
	logic [2:0]                scan_bit;
	logic                      scan_last;
	logic [PW-1:0]             hit_end;
	logic [PW-1:0]             hit_first;
	logic [AW-1:0]             first_byte, end_byte;
	logic [2:0]                lo, hi;
	logic [7:0]                mark_mask;
	logic [7:0]                bit_mask;
	bra_pkg::scan_ctl_t        scan_ctl;

	// Map an absolute index into a map position and check it lies in use.
	always_comb begin
		rel    = idx_q - base;
		in_rng = (idx_q >= base) && (rel[bra_pkg::IDX_W-1:3] < 29'(n_bytes));
	end

	bra_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.map_byte (mem_rdata_q),
		.want     (want_q),
		.hit      (scan_hit),
		.hit_bit  (scan_bit)
	);

	// Position of a found run and the byte masks for marking it.
	always_comb begin
		scan_last  = ((CW'(da_s1) + CW'(1)) == n_bytes);
		hit_end    = {da_s1, scan_bit};
		hit_first  = hit_end + PW'(1) - PW'(want_q);
		first_byte = first_q[PW-1:3];
		end_byte   = end_q[PW-1:3];
		lo         = (ma_s1 == first_byte) ? first_q[2:0] : 3'd0;
		hi         = (ma_s1 == end_byte) ? end_q[2:0] : 3'd7;
		mark_mask  = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
		bit_mask   = 8'd1 << pos_q[2:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bra_pkg::ST_CLEAR: begin
				if (clr_q == AW'(MAP_BYTES - 1)) state_d = bra_pkg::ST_IDLE;
			end
			bra_pkg::ST_IDLE: begin
				if (req.valid) state_d = bra_pkg::ST_LOCATE;
			end
			bra_pkg::ST_LOCATE: begin
				case (op_q)
					bra_pkg::OP_TEST, bra_pkg::OP_WRITE: begin
						state_d = in_rng ? bra_pkg::ST_RMW : bra_pkg::ST_RESP;
					end
					bra_pkg::OP_ALLOC: begin
						state_d = (want_q == '0 || n_bytes == '0) ? bra_pkg::ST_RESP
							: bra_pkg::ST_SCAN;
					end
					default: state_d = bra_pkg::ST_RESP;
				endcase
			end
			bra_pkg::ST_RMW: state_d = bra_pkg::ST_RESP;
			bra_pkg::ST_SCAN: begin
				if (dv_s1 && scan_hit) state_d = bra_pkg::ST_MARK;
				else if (dv_s1 && scan_last) state_d = bra_pkg::ST_RESP;
			end
			bra_pkg::ST_MARK: begin
				if (mv_s1 && ma_s1 == end_byte) state_d = bra_pkg::ST_RESP;
			end
			bra_pkg::ST_RESP: begin
				if (out_free) state_d = bra_pkg::ST_IDLE;
			end
			default: state_d = bra_pkg::ST_IDLE;
		endcase
	end

	// State outputs: memory ports, handshake and tracker control.
	always_comb begin
		mem_re     = 1'b0;
		mem_ra     = '0;
		mem_we     = 1'b0;
		mem_wa     = '0;
		mem_wd     = '0;
		req.ready  = 1'b0;
		res_push   = 1'b0;
		scan_ctl   = '0;
		case (state_q)
			bra_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
			end
			bra_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			bra_pkg::ST_LOCATE: begin
				scan_ctl.clear = 1'b1;
				if (in_rng && (op_q == bra_pkg::OP_TEST || op_q == bra_pkg::OP_WRITE)) begin
					mem_re = 1'b1;
					mem_ra = rel[PW-1:3];
				end
			end
			bra_pkg::ST_RMW: begin
				if (op_q == bra_pkg::OP_WRITE) begin
					mem_we = 1'b1;
					mem_wa = pos_q[PW-1:3];
					mem_wd = wval_q ? (mem_rdata_q | bit_mask) : (mem_rdata_q & ~bit_mask);
				end
			end
			bra_pkg::ST_SCAN: begin
				scan_ctl.step = dv_s1;
				if (rd_q < n_bytes) begin
					mem_re = 1'b1;
					mem_ra = rd_q[AW-1:0];
				end
			end
			bra_pkg::ST_MARK: begin
				if (mk_go_q) begin
					mem_re = 1'b1;
					mem_ra = mk_q;
				end
				if (mv_s1) begin
					mem_we = 1'b1;
					mem_wa = ma_s1;
					mem_wd = mem_rdata_q | mark_mask;
				end
			end
			bra_pkg::ST_RESP: begin
				res_push = out_free;
			end
			default: ;
		endcase
	end

	// Map memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) mem_rdata_q <= mem[mem_ra];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bra_pkg::ST_CLEAR;
			clr_q   <= '0;
			rd_q    <= '0;
			dv_s1   <= 1'b0;
			mk_q    <= '0;
			mk_go_q <= 1'b0;
			mv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			dv_s1   <= (state_q == bra_pkg::ST_SCAN) && mem_re;
			mv_s1   <= (state_q == bra_pkg::ST_MARK) && mk_go_q;
			if (state_q == bra_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == bra_pkg::ST_LOCATE) rd_q <= '0;
			else if (state_q == bra_pkg::ST_SCAN && mem_re) rd_q <= rd_q + CW'(1);
			if (state_q == bra_pkg::ST_SCAN && dv_s1 && scan_hit) begin
				mk_q    <= hit_first[PW-1:3];
				mk_go_q <= 1'b1;
			end else if (state_q == bra_pkg::ST_MARK && mk_go_q) begin
				mk_q    <= mk_q + AW'(1);
				mk_go_q <= (mk_q != end_byte);
			end
		end
	end

	// Request capture, read and mark addresses, and the result word.
	always_ff @(posedge clk) begin
		da_s1 <= rd_q[AW-1:0];
		ma_s1 <= mk_q;
		if (state_q == bra_pkg::ST_IDLE && req.valid) begin
			op_q   <= req.opcode;
			idx_q  <= req.bit_index;
			wval_q <= req.write_value;
			want_q <= req.run_length;
			res_q  <= '0;
		end
		if (state_q == bra_pkg::ST_LOCATE) pos_q <= rel[PW-1:0];
		if (state_q == bra_pkg::ST_RMW && op_q == bra_pkg::OP_TEST) begin
			res_q.bit_state <= mem_rdata_q[pos_q[2:0]];
		end
		if (state_q == bra_pkg::ST_SCAN && dv_s1 && scan_hit) begin
			first_q <= hit_first;
			end_q   <= hit_end;
		end
		if (state_q == bra_pkg::ST_MARK && mv_s1 && ma_s1 == end_byte) begin
			res_q.run_found <= 1'b1;
			res_q.run_start <= base + bra_pkg::IDX_W'(first_q);
		end
	end

	assign res = res_q;

endmodule
